/* rtl/core/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Coefficient width, derived widths, status codes and the pipeline payloads.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned CoefWidth = 16;
  localparam int unsigned MagWidth  = CoefWidth + 1;       // |coef|, incl. -2^(n-1)
  localparam int unsigned DiscWidth = 2 * CoefWidth + 2;   // magnitude of b^2 + 4|ac|
  localparam int unsigned SqrtWidth = CoefWidth + 1;       // floor root of DiscWidth bits
  localparam int unsigned NumWidth  = CoefWidth + 3;       // -b +/- s, signed
  localparam int unsigned DenWidth  = CoefWidth + 2;       // |2a|
  localparam int unsigned RootWidth = 17;
  localparam int unsigned QuoWidth  = NumWidth;

  typedef enum logic [1:0] {
    StatusNotQuad = 2'd0,
    StatusNoRoot  = 2'd1,
    StatusOneRoot = 2'd2,
    StatusTwoRoot = 2'd3
  } status_e;

  // Item state while the root is extracted.
  typedef struct packed {
    status_e                       status;
    logic signed [CoefWidth-1:0]   coef_a;
    logic signed [CoefWidth-1:0]   coef_b;
    logic [DiscWidth-1:0]          rem;    // disc - r*r so far
    logic [SqrtWidth-1:0]          root;   // partial root
  } sqrt_item_t;

  // Item state while the two quotients are formed.
  typedef struct packed {
    status_e                       status;
    logic                          inexact;
    logic                          neg_one;  // sign of root one
    logic                          neg_two;
    logic [NumWidth-1:0]           num_one;  // adjusted magnitude
    logic [NumWidth-1:0]           num_two;
    logic [DenWidth-1:0]           den;
    logic [NumWidth-1:0]           rem_one;
    logic [NumWidth-1:0]           rem_two;
    logic [QuoWidth-1:0]           quo_one;
    logic [QuoWidth-1:0]           quo_two;
  } div_item_t;

endpackage

/* rtl/core/qrs_disc.sv */
// ----------------------------------------------------------------------------
// qrs_disc: discriminant stages
// Two register stages: products |b|^2 and |a||c|, then sign and difference.
// ----------------------------------------------------------------------------
module qrs_disc (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   adv_i,
  input  logic                                   valid_i,
  input  logic signed [qrs_pkg::CoefWidth-1:0]   coef_a_i,
  input  logic signed [qrs_pkg::CoefWidth-1:0]   coef_b_i,
  input  logic signed [qrs_pkg::CoefWidth-1:0]   coef_c_i,
  output logic                                   valid_o,
  output qrs_pkg::sqrt_item_t                    item_o
);

  localparam int unsigned MW = qrs_pkg::MagWidth;
  localparam int unsigned DW = qrs_pkg::DiscWidth;

  logic [MW-1:0]   mag_a, mag_b, mag_c;
  logic            v1_q, v2_q;
  logic [2*MW-1:0] b2_q, ac_q;
  logic            same_sign_q, a_zero_q;
  logic signed [qrs_pkg::CoefWidth-1:0] a1_q, b1_q;
  qrs_pkg::sqrt_item_t item_d, item_q;
  logic [DW:0]     four_ac, disc_pos, disc_neg;

  assign mag_a = coef_a_i[qrs_pkg::CoefWidth-1] ? MW'(-{coef_a_i[qrs_pkg::CoefWidth-1], coef_a_i})
                                                 : MW'({1'b0, coef_a_i});
  assign mag_b = coef_b_i[qrs_pkg::CoefWidth-1] ? MW'(-{coef_b_i[qrs_pkg::CoefWidth-1], coef_b_i})
                                                 : MW'({1'b0, coef_b_i});
  assign mag_c = coef_c_i[qrs_pkg::CoefWidth-1] ? MW'(-{coef_c_i[qrs_pkg::CoefWidth-1], coef_c_i})
                                                 : MW'({1'b0, coef_c_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b2_q        <= mag_b * mag_b;
      ac_q        <= mag_a * mag_c;
      same_sign_q <= (coef_c_i != '0) && (coef_a_i[qrs_pkg::CoefWidth-1] ==
                                          coef_c_i[qrs_pkg::CoefWidth-1]);
      a_zero_q    <= (coef_a_i == '0);
      a1_q        <= coef_a_i;
      b1_q        <= coef_b_i;
      item_q      <= item_d;
    end
  end

  assign four_ac  = (DW+1)'({ac_q[DW-3:0], 2'b00});
  assign disc_pos = (DW+1)'(b2_q) + four_ac;
  assign disc_neg = (DW+1)'(b2_q) - four_ac;

  always_comb begin
    item_d        = '0;
    item_d.coef_a = a1_q;
    item_d.coef_b = b1_q;
    if (a_zero_q) begin
      item_d.status = qrs_pkg::StatusNotQuad;
    end else if (same_sign_q && disc_neg[DW]) begin
      item_d.status = qrs_pkg::StatusNoRoot;
    end else begin
      item_d.rem    = same_sign_q ? disc_neg[DW-1:0] : disc_pos[DW-1:0];
      item_d.status = (item_d.rem == '0) ? qrs_pkg::StatusOneRoot
                                         : qrs_pkg::StatusTwoRoot;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/qrs_sqrt.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined floor square root
// One restoring root bit per stage, most significant first.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  qrs_pkg::sqrt_item_t   item_i,
  output logic                  valid_o,
  output qrs_pkg::sqrt_item_t   item_o
);

  localparam int unsigned SW = qrs_pkg::SqrtWidth;
  localparam int unsigned DW = qrs_pkg::DiscWidth;

  logic                v_q   [SW];
  qrs_pkg::sqrt_item_t stg_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_bit
    localparam int unsigned Bit = SW - 1 - k;
    qrs_pkg::sqrt_item_t in_it, out_it;
    logic                in_v;
    logic [DW+1:0]       trial;
    logic [DW+1:0]       rem_ext;

    if (k == 0) begin : g_first
      assign in_it = item_i;
      assign in_v  = valid_i;
    end else begin : g_next
      assign in_it = stg_q[k-1];
      assign in_v  = v_q[k-1];
    end

    // (r + 2^Bit)^2 - r^2 = 2^(Bit+1) r + 2^(2 Bit)
    assign trial   = ((DW+2)'(in_it.root) << (Bit + 1)) + ((DW+2)'(1) << (2 * Bit));
    assign rem_ext = (DW+2)'(in_it.rem);

    always_comb begin
      out_it = in_it;
      if (trial <= rem_ext) begin
        out_it.rem       = DW'(rem_ext - trial);
        out_it.root[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[k] <= out_it;
      end
    end
  end

  assign valid_o = v_q[SW-1];
  assign item_o  = stg_q[SW-1];

endmodule

/* rtl/core/qrs_div.sv */
// ----------------------------------------------------------------------------
// qrs_div: setup and pipelined restoring division of both roots
// One setup stage, then one quotient bit per stage for both roots at once.
// ----------------------------------------------------------------------------
module qrs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  qrs_pkg::sqrt_item_t   item_i,
  output logic                  valid_o,
  output qrs_pkg::status_e      status_o,
  output logic [qrs_pkg::RootWidth-1:0] root_one_o,
  output logic [qrs_pkg::RootWidth-1:0] root_two_o
);

  localparam int unsigned NW = qrs_pkg::NumWidth;
  localparam int unsigned QW = qrs_pkg::QuoWidth;
  localparam int unsigned CW = qrs_pkg::CoefWidth;

  qrs_pkg::div_item_t setup_d, setup_q;
  logic               setup_v_q;
  logic               v_q   [QW];
  qrs_pkg::div_item_t stg_q [QW];

  // Setup: signed numerators, fold the denominator sign in, and turn
  // truncation of (n + g)/d into truncation of an integer magnitude.
  always_comb begin
    logic signed [NW-1:0] s_ext, nb, n1, n2, m1, m2;
    logic                 neg_d, g1neg, g2neg;
    logic                 inexact;
    s_ext   = NW'($signed({1'b0, item_i.root}));
    nb      = -NW'(item_i.coef_b);
    neg_d   = item_i.coef_a[CW-1];
    inexact = (item_i.rem != '0);
    n1      = nb + s_ext;
    n2      = nb - s_ext;
    // after folding the sign of d: numerator m, fraction sign
    m1      = neg_d ? -n1 : n1;
    m2      = neg_d ? -n2 : n2;
    g1neg   = neg_d;   // root one fraction +g, flipped with d
    g2neg   = !neg_d;
    setup_d          = '0;
    setup_d.status   = item_i.status;
    setup_d.inexact  = inexact;
    setup_d.den      = neg_d ? -{item_i.coef_a[CW-1], item_i.coef_a, 1'b0}
                             : qrs_pkg::DenWidth'({item_i.coef_a, 1'b0});
    // value (m + g): positive if m>0 or (m==0 and g>0)
    if (m1 > 0 || (m1 == 0 && inexact && !g1neg)) begin
      setup_d.neg_one = 1'b0;
      setup_d.num_one = NW'((inexact && g1neg) ? m1 - 1 : m1);
    end else begin
      setup_d.neg_one = 1'b1;
      setup_d.num_one = NW'((inexact && !g1neg) ? -m1 - 1 : -m1);
    end
    if (m2 > 0 || (m2 == 0 && inexact && !g2neg)) begin
      setup_d.neg_two = 1'b0;
      setup_d.num_two = NW'((inexact && g2neg) ? m2 - 1 : m2);
    end else begin
      setup_d.neg_two = 1'b1;
      setup_d.num_two = NW'((inexact && !g2neg) ? -m2 - 1 : -m2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_v_q <= 1'b0;
    end else if (adv_i) begin
      setup_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      setup_q <= setup_d;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int unsigned Bit = QW - 1 - k;
    qrs_pkg::div_item_t in_it, out_it;
    logic               in_v;
    logic [NW:0]        r1, r2;

    if (k == 0) begin : g_first
      assign in_it = setup_q;
      assign in_v  = setup_v_q;
    end else begin : g_next
      assign in_it = stg_q[k-1];
      assign in_v  = v_q[k-1];
    end

    assign r1 = {in_it.rem_one, in_it.num_one[Bit]};
    assign r2 = {in_it.rem_two, in_it.num_two[Bit]};

    always_comb begin
      out_it = in_it;
      out_it.rem_one = r1[NW-1:0];
      out_it.rem_two = r2[NW-1:0];
      if (r1 >= (NW+1)'(in_it.den)) begin
        out_it.rem_one      = NW'(r1 - (NW+1)'(in_it.den));
        out_it.quo_one[Bit] = 1'b1;
      end
      if (r2 >= (NW+1)'(in_it.den)) begin
        out_it.rem_two      = NW'(r2 - (NW+1)'(in_it.den));
        out_it.quo_two[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[k] <= out_it;
      end
    end
  end

  // Final sign and masking of fields not produced.
  always_comb begin
    qrs_pkg::div_item_t last;
    logic [QW-1:0]      q1, q2;
    last       = stg_q[QW-1];
    q1         = last.neg_one ? QW'(-last.quo_one) : last.quo_one;
    q2         = last.neg_two ? QW'(-last.quo_two) : last.quo_two;
    status_o   = last.status;
    root_one_o = '0;
    root_two_o = '0;
    if (last.status == qrs_pkg::StatusOneRoot || last.status == qrs_pkg::StatusTwoRoot) begin
      root_one_o = q1[qrs_pkg::RootWidth-1:0];
    end
    if (last.status == qrs_pkg::StatusTwoRoot) begin
      root_two_o = q2[qrs_pkg::RootWidth-1:0];
    end
  end

  assign valid_o = v_q[QW-1];

endmodule

/* rtl/core/quadratic_root_solver.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0
// Pipelined discriminant, floor square root and truncating division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid_i/ready_o) carries coef_a_i, coef_b_i, coef_c_i.
//   Output channel (valid_o/ready_i) carries status_o, root_one_o, root_two_o.
//   One transfer in gives exactly one transfer out, in order.
//   Status: not quadratic, no real root, one root, two roots; a root field
//   that is not produced reads zero. Roots are truncated toward zero.
//   Throughput: one item per cycle while the pipe advances. Stages: 2
//   discriminant stages, 17 root stages (one root bit each), 1 division setup
//   stage and 19 quotient stages (one bit each, both roots in parallel), then
//   the output register that drives valid_o.
//   Stall: the whole pipe advances together whenever the output register is
//   empty or being drained; when the receiver holds ready_i low with a result
//   waiting, the pipe holds and ready_o drops. Nothing is lost or repeated.
//   Reset (rst_ni low, asynchronous) clears every valid bit; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [qrs_pkg::CoefWidth-1:0] coef_a_i,
  input  logic signed [qrs_pkg::CoefWidth-1:0] coef_b_i,
  input  logic signed [qrs_pkg::CoefWidth-1:0] coef_c_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [1:0]                           status_o,
  output logic signed [qrs_pkg::RootWidth-1:0] root_one_o,
  output logic signed [qrs_pkg::RootWidth-1:0] root_two_o
);

  logic                 adv;
  logic                 disc_v, sqrt_v, div_v;
  qrs_pkg::sqrt_item_t  disc_it, sqrt_it;
  qrs_pkg::status_e     div_status;
  logic [qrs_pkg::RootWidth-1:0] div_r1, div_r2;
  logic                 out_v_q;
  logic [1:0]           status_q;
  logic [qrs_pkg::RootWidth-1:0] r1_q, r2_q;

  // Advance the pipe whenever the output register can take what comes out.
  assign adv     = !out_v_q || ready_i;
  assign ready_o = adv;

  qrs_disc u_disc (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(valid_i),
    .coef_a_i, .coef_b_i, .coef_c_i,
    .valid_o(disc_v), .item_o(disc_it)
  );

  qrs_sqrt u_sqrt (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(disc_v), .item_i(disc_it),
    .valid_o(sqrt_v), .item_o(sqrt_it)
  );

  qrs_div u_div (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(sqrt_v), .item_i(sqrt_it),
    .valid_o(div_v), .status_o(div_status),
    .root_one_o(div_r1), .root_two_o(div_r2)
  );

  // Output register: load on advance, hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= div_status;
      r1_q     <= div_r1;
      r2_q     <= div_r2;
    end
  end

  assign valid_o    = out_v_q;
  assign status_o   = status_q;
  assign root_one_o = r1_q;
  assign root_two_o = r2_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(status_o) && $stable(root_one_o))
    else $error("result changed during stall");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |-> !ready_o)
    else $error("input taken while output stalled");
  a_root_two_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != qrs_pkg::StatusTwoRoot |-> root_two_o == '0)
    else $error("second root not cleared");
`endif

endmodule

/* tb/quadratic_root_solver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb: self-checking bench for the quadratic root solver
// Drives coefficient sets through the valid/ready input channel with random
// gaps, predicts status and truncated roots with exact wide arithmetic, and
// compares every output transfer in order against the predicted queue.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned PipeDepth = 40;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    qrs_pkg::status_e                     status;
    logic signed [qrs_pkg::RootWidth-1:0] root_one;
    logic signed [qrs_pkg::RootWidth-1:0] root_two;
  } roots_t;

  // Track predicted roots and compare each output transfer with the oldest.
  class root_scoreboard;
    roots_t pending[$];
    int unsigned mismatches;

    // Floor square root of a non-negative 66-bit value.
    function automatic logic [33:0] floor_sqrt(logic [65:0] disc);
      logic [33:0] r;
      logic [33:0] t;
      r = '0;
      for (int k = 33; k >= 0; k--) begin
        t = r | (34'd1 << k);
        if ({68'd0, t} * {68'd0, t} <= {36'd0, disc}) r = t;
      end
      return r;
    endfunction

    // Truncate (n + frac) / den toward zero; frac has sign fs in (-1,1), den > 0.
    function automatic longint trunc_div(longint n, int fs, longint den);
      if (fs == 0) return n / den;
      if (n > 0 || (n == 0 && fs > 0)) return (fs > 0 ? n : n - 1) / den;
      n = -n;
      fs = -fs;
      return -((fs > 0 ? n : n - 1) / den);
    endfunction

    function automatic void note_coefs(logic signed [qrs_pkg::CoefWidth-1:0] ca,
                                       logic signed [qrs_pkg::CoefWidth-1:0] cb,
                                       logic signed [qrs_pkg::CoefWidth-1:0] cc);
      roots_t exp_r;
      logic signed [69:0] disc;
      logic [33:0] s;
      int frac;
      longint den, np, nm, r1, r2;
      exp_r = '{qrs_pkg::StatusNotQuad, '0, '0};
      if (ca != 0) begin
        disc = 70'(cb) * 70'(cb) - 70'sd4 * 70'(ca) * 70'(cc);
        if (disc < 0) begin
          exp_r.status = qrs_pkg::StatusNoRoot;
        end else begin
          s = floor_sqrt(disc[65:0]);
          frac = (70'(s) * 70'(s) == disc) ? 0 : 1;
          den = 2 * longint'(ca);
          np = -longint'(cb) + longint'(s);
          nm = -longint'(cb) - longint'(s);
          if (den > 0) begin
            r1 = trunc_div(np, frac, den);
            r2 = trunc_div(nm, -frac, den);
          end else begin
            r1 = trunc_div(-np, -frac, -den);
            r2 = trunc_div(-nm, frac, -den);
          end
          exp_r.root_one = r1[qrs_pkg::RootWidth-1:0];
          if (disc == 0) begin
            exp_r.status = qrs_pkg::StatusOneRoot;
          end else begin
            exp_r.status = qrs_pkg::StatusTwoRoot;
            exp_r.root_two = r2[qrs_pkg::RootWidth-1:0];
          end
        end
      end
      pending.push_back(exp_r);
    endfunction

    function automatic void check_roots(logic [1:0] st,
                                        logic [qrs_pkg::RootWidth-1:0] r1,
                                        logic [qrs_pkg::RootWidth-1:0] r2);
      roots_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", st);
        return;
      end
      exp_r = pending.pop_front();
      if (st !== exp_r.status || r1 !== exp_r.root_one || r2 !== exp_r.root_two) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d %0d got %0d %0d %0d", exp_r.status,
                   exp_r.root_one, exp_r.root_two, st, $signed(r1), $signed(r2));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic signed [qrs_pkg::CoefWidth-1:0] coef_a_i = '0;
  logic signed [qrs_pkg::CoefWidth-1:0] coef_b_i = '0;
  logic signed [qrs_pkg::CoefWidth-1:0] coef_c_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [1:0] status_o;
  logic signed [qrs_pkg::RootWidth-1:0] root_one_o;
  logic signed [qrs_pkg::RootWidth-1:0] root_two_o;

  root_scoreboard roots_sb = new();
  bit idle_free = 1'b0;      // long stretch with no idling on either side
  bit hold_off = 1'b0;       // receiver holds ready_i low for a long stretch
  longint unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quadratic_root_solver DUT (.*);

  // Receiver: random stalls, a long hold-off on request; check every transfer.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && valid_o && ready_i) roots_sb.check_roots(status_o, root_one_o, root_two_o);
    if (hold_off) ready_i <= 1'b0;
    else ready_i <= idle_free || ($urandom_range(99) >= 20);
  end

  // Offer one coefficient set and hold it until the transfer; drop valid
  // only while idling, so sets can follow back to back.
  task automatic send_coefs(logic [qrs_pkg::CoefWidth-1:0] ca,
                            logic [qrs_pkg::CoefWidth-1:0] cb,
                            logic [qrs_pkg::CoefWidth-1:0] cc);
    while (!idle_free && $urandom_range(99) < 20) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    coef_a_i <= ca;
    coef_b_i <= cb;
    coef_c_i <= cc;
    do @(posedge clk_i); while (!ready_o);
    roots_sb.note_coefs(ca, cb, cc);
  endtask

  function automatic logic [qrs_pkg::CoefWidth-1:0] rand_coef();
    case ($urandom_range(5))
      0: return qrs_pkg::CoefWidth'($urandom_range(7) - 3);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      2: return qrs_pkg::CoefWidth'($urandom_range(255) - 128);
      default: return qrs_pkg::CoefWidth'($urandom);
    endcase
  endfunction

  // Stop offering and wait for every expected result.
  task automatic drain();
    valid_i <= 1'b0;
    while (roots_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [qrs_pkg::CoefWidth-1:0] ra, rb, rc, rr;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: not quadratic, no root, one root, two roots, field extremes.
    send_coefs(16'd0, 16'd5, 16'd7);
    send_coefs(16'd0, 16'h8000, 16'h7fff);
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, 16'hfffd, 16'd2);
    send_coefs(16'hffff, 16'd0, 16'd4);
    send_coefs(16'd2, 16'd1, 16'hffff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'd1, 16'h8000, 16'd0);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'hffff, 16'h7fff, 16'h7fff);
    send_coefs(16'd3, 16'd0, 16'd0);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'haaaa, 16'h5555, 16'haaaa);
    send_coefs(16'h5555, 16'haaaa, 16'h5555);
    // Sender pause: wait for every expected result.
    drain();

    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (i == 300) idle_free = 1'b1;
      if (i == 500) idle_free = 1'b0;
      if (i == 800) begin
        // Hold off the receiver while the sender keeps offering.
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 1200) drain();
      ra = rand_coef();
      rb = rand_coef();
      rc = rand_coef();
      if ($urandom_range(9) == 0) ra = '0;
      if ($urandom_range(7) == 0) begin
        // Double root: b = -2*a*r, c = a*r*r.
        rr = qrs_pkg::CoefWidth'($urandom_range(40) - 20);
        ra = qrs_pkg::CoefWidth'($urandom_range(20) - 10);
        if (ra == 0) ra = 16'd1;
        rb = qrs_pkg::CoefWidth'(-2 * ra * rr);
        rc = ra * rr * rr;
      end
      send_coefs(ra, rb, rc);
    end

    drain();
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (roots_sb.mismatches == 0 && roots_sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
